// File: hdl/assert_macros.svh
// assertion macros used by the receiver decode logic
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/cebr_pkg.sv
// types and constants of the block receiver
// no dependencies
package cebr_pkg;

  localparam logic [7:0] SYNC_BYTE_A = 8'h55;
  localparam logic [7:0] SYNC_BYTE_B = 8'h01;
  localparam logic [7:0] SYNC_BYTE_C = 8'h8A;
  localparam logic [7:0] KEY_REPLY   = 8'h75;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  // sync hunt and link state, one-hot
  typedef enum logic [3:0] {
    HUNT_A = 4'b0001,
    HUNT_B = 4'b0010,
    HUNT_C = 4'b0100,
    LINKED = 4'b1000
  } sync_state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       block_end;
    logic [7:0] frame_counter;
    logic       link_synced;
  } result_t;

endpackage

// File: hdl/cebr_in_stage.sv
// input register of the block receiver
// depends on cebr_pkg
module cebr_in_stage import cebr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       held;
  logic [7:0] held_byte;

  assign in_ready   = !held || advance;
  assign item_valid = held;
  assign item_byte  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte & BYTE_MASK;
    end
  end

endmodule

// File: hdl/cebr_decode.sv
// sync hunt, block deframing and reply generation
// depends on cebr_pkg and assert_macros.svh
`include "assert_macros.svh"

module cebr_decode import cebr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] item_byte,
  output result_t    res
);

  sync_state_t sync_state, sync_state_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  counter_reg, counter_reg_next;
  logic        start;

  always_comb begin
    sync_state_next  = sync_state;
    bytes_seen_next  = bytes_seen;
    bytes_left_next  = bytes_left;
    counter_reg_next = counter_reg;
    start            = (bytes_seen == 8'd0);
    res              = '0;
    case (sync_state)
      HUNT_A: begin
        if (item_byte == SYNC_BYTE_A) sync_state_next = HUNT_B;
      end
      HUNT_B: begin
        if (item_byte == SYNC_BYTE_B) sync_state_next = HUNT_C;
      end
      HUNT_C: begin
        if (item_byte == SYNC_BYTE_C) begin
          sync_state_next = LINKED;
          res.echo_valid  = 1'b1;
          res.echo_byte   = KEY_REPLY;
        end
      end
      LINKED: begin
        res.data_valid    = 1'b1;
        res.data_byte     = item_byte;
        res.byte_position = bytes_seen;
        // last byte of a block is not answered, unless it is the length byte
        if (start || bytes_left > 8'd1) begin
          res.echo_valid = 1'b1;
          res.echo_byte  = item_byte ^ BYTE_MASK;
        end
        if (start) begin
          bytes_left_next = item_byte;
        end else begin
          if (bytes_seen == 8'd1) counter_reg_next = item_byte;
          bytes_left_next = bytes_left - 8'd1;
        end
        if (bytes_left_next == 8'd0) begin
          res.block_end   = 1'b1;
          bytes_seen_next = 8'd0;
        end else begin
          bytes_seen_next = bytes_seen + 8'd1;
        end
      end
      default: begin
        sync_state_next = HUNT_A;
      end
    endcase
    res.frame_counter = counter_reg_next;
    res.link_synced   = (sync_state_next == LINKED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_state  <= HUNT_A;
      bytes_seen  <= 8'd0;
      bytes_left  <= 8'd0;
      counter_reg <= 8'd0;
    end else if (advance) begin
      sync_state  <= sync_state_next;
      bytes_seen  <= bytes_seen_next;
      bytes_left  <= bytes_left_next;
      counter_reg <= counter_reg_next;
    end
  end

  `ASSERT_NEXT(a_link_sticky, clk, rst, sync_state == LINKED, sync_state == LINKED)
  `ASSERT_IMPL(a_data_needs_link, clk, rst, res.data_valid, res.link_synced)
  `ASSERT_IMPL(a_end_in_block, clk, rst, res.block_end, res.data_valid)
  `ASSERT_IMPL(a_key_only_at_sync, clk, rst, res.echo_valid && !res.data_valid,
               res.echo_byte == KEY_REPLY)
  `ASSERT_NEXT(a_block_restart, clk, rst, advance && res.block_end, bytes_seen == 8'd0)

endmodule

// File: hdl/cebr_out_stage.sv
// result register of the block receiver
// depends on cebr_pkg
module cebr_out_stage import cebr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    full;
  result_t held;

  assign advance   = item_valid && (!full || out_ready);
  assign out_valid = full;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!full || out_ready) begin
      full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= res;
    end
  end

endmodule

// File: hdl/complement_echo_block_receiver.sv
// top level of the block receiver: input register, decode logic, result register
// throughput one byte per cycle while results are taken; the result register frees up in the cycle it is taken
// synchronous active-high reset empties both registers and restarts the sync hunt
// reset also clears the block position, remaining count and stored block counter
// depends on cebr_pkg, cebr_in_stage, cebr_decode, cebr_out_stage
module complement_echo_block_receiver import cebr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // received byte channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // one result per received byte
  output logic       out_valid,
  input  logic       out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_byte,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic [7:0] byte_position,
  output logic       block_end,
  output logic [7:0] frame_counter,
  output logic       link_synced
);

  // advance moves the held byte through decode into the result register,
  // and is the only moment the link state changes
  logic       advance;
  logic       item_valid;
  logic [7:0] item_byte;
  result_t    res;
  result_t    out_res;

  // input register
  cebr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  // sync hunt, then length / counter deframing with complement replies
  cebr_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item_byte (item_byte),
    .res       (res)
  );

  // result register, loads a held byte whenever it is empty or its transfer completes
  cebr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // unpack the result fields onto their ports
  assign echo_valid    = out_res.echo_valid;
  assign echo_byte     = out_res.echo_byte;
  assign data_valid    = out_res.data_valid;
  assign data_byte     = out_res.data_byte;
  assign byte_position = out_res.byte_position;
  assign block_end     = out_res.block_end;
  assign frame_counter = out_res.frame_counter;
  assign link_synced   = out_res.link_synced;

endmodule

// File: tb/tb_complement_echo_block_receiver.sv
// testbench of complement_echo_block_receiver: sync hunt, block deframing and echo replies
// depends on cebr_pkg and the receiver rtl; scoreboard compares every result with a directed row or a predictor
`timescale 1ns / 100ps

module tb_complement_echo_block_receiver;
  import cebr_pkg::*;

  localparam int NUM_ITEMS = 1400;
  localparam int LONG_BLOCK_AT = 40;   // block index that carries the longest length
  localparam int DRAIN_CYCLES = 10;    // wait after the drain for any stray result, with margin over the rtl pipeline
  localparam int WATCHDOG_NS = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [7:0] byte_position;
  logic       block_end;
  logic [7:0] frame_counter;
  logic       link_synced;

  // one row of the directed table; want is used only when fixed is set
  typedef struct {
    logic [7:0] rx;
    bit         fixed;
    result_t    want;
  } rx_row_t;

  rx_row_t     rx_table[$];
  result_t     expected_replies[$];
  int          errors = 0;
  int          items_sent = 0;
  int          src_idle_pct = 10;
  int          sink_idle_pct = 54;

  // predictor state
  sync_state_t link_state = HUNT_A;
  logic [7:0]  blk_pos = 8'h00;
  logic [7:0]  blk_left = 8'h00;
  logic [7:0]  blk_counter = 8'h00;

  complement_echo_block_receiver DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .echo_valid    (echo_valid),
    .echo_byte     (echo_byte),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .byte_position (byte_position),
    .block_end     (block_end),
    .frame_counter (frame_counter),
    .link_synced   (link_synced)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // builds a fixed result for the directed table
  function automatic result_t reply(input logic ev, input logic [7:0] eb, input logic dv,
                                    input logic [7:0] db, input logic [7:0] pos,
                                    input logic be, input logic [7:0] fc, input logic ls);
    result_t r;
    r.echo_valid    = ev;
    r.echo_byte     = eb;
    r.data_valid    = dv;
    r.data_byte     = db;
    r.byte_position = pos;
    r.block_end     = be;
    r.frame_counter = fc;
    r.link_synced   = ls;
    return r;
  endfunction

  // next result for one received byte; advances the predictor state
  function automatic result_t predict_reply(input logic [7:0] b);
    result_t    r;
    logic [7:0] pos;
    r = '0;
    if (link_state != LINKED) begin
      // hunting: out-of-order bytes are simply dropped, the hunt never restarts
      if (link_state == HUNT_A && b == SYNC_BYTE_A) begin
        link_state = HUNT_B;
      end else if (link_state == HUNT_B && b == SYNC_BYTE_B) begin
        link_state = HUNT_C;
      end else if (link_state == HUNT_C && b == SYNC_BYTE_C) begin
        link_state   = LINKED;
        r.echo_valid = 1'b1;
        r.echo_byte  = KEY_REPLY;
      end
    end else begin
      pos             = blk_pos;
      r.data_valid    = 1'b1;
      r.data_byte     = b;
      r.byte_position = pos;
      // every byte but the last of a block is answered with its complement; the length byte always is
      if (pos == 8'd0 || blk_left > 8'd1) begin
        r.echo_valid = 1'b1;
        r.echo_byte  = b ^ BYTE_MASK;
      end
      if (pos == 8'd0) begin
        blk_left = b;
      end else begin
        if (pos == 8'd1)
          blk_counter = b;
        blk_left = blk_left - 8'd1;
      end
      if (blk_left == 8'd0) begin
        r.block_end = 1'b1;
        blk_pos     = 8'd0;
      end else begin
        blk_pos = pos + 8'd1;
      end
    end
    r.frame_counter = blk_counter;
    r.link_synced   = (link_state == LINKED);
    return r;
  endfunction

  task automatic add_row(input logic [7:0] rx, input bit fixed, input result_t want);
    rx_row_t row;
    row.rx    = rx;
    row.fixed = fixed;
    row.want  = want;
    rx_table.push_back(row);
  endtask

  // one byte on the input channel; called at a rising edge, returns at the edge of the transfer
  task automatic send_rx(input logic [7:0] b, input bit fixed, input result_t want);
    result_t predicted;
    // random sender gaps
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    predicted = predict_reply(b);
    // fixed rows still run through the predictor to keep its state in step
    expected_replies.push_back(fixed ? want : predicted);
    items_sent++;
    do
      @(posedge clk);
    while (!in_ready);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: check each transfer against the oldest expectation, then stall at random
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t ns: result with nothing expected, echo %02h data %02h pos %02h",
                 $time, echo_byte, data_byte, byte_position);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        check_field("echo_valid", 8'(want.echo_valid), 8'(echo_valid));
        check_field("echo_byte", want.echo_byte, echo_byte);
        check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
        check_field("data_byte", want.data_byte, data_byte);
        check_field("byte_position", want.byte_position, byte_position);
        check_field("block_end", 8'(want.block_end), 8'(block_end));
        check_field("frame_counter", want.frame_counter, frame_counter);
        check_field("link_synced", 8'(want.link_synced), 8'(link_synced));
      end
    end
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // hard limit on the run
  initial begin
    #WATCHDOG_NS;
    $display("tb_complement_echo_block_receiver: FAIL");
    $finish;
  end

  initial begin
    int blocks;
    int len;
    int pick;
    int phase;

    // hunting: out-of-order sync bytes, a repeated first byte and noise are all ignored
    add_row(8'h00, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(SYNC_BYTE_B, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(SYNC_BYTE_C, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(SYNC_BYTE_A, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(SYNC_BYTE_A, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(SYNC_BYTE_B, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    add_row(8'hFF, 1'b1, reply(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'h00, 0));
    // final sync byte answers with the key complement and links up
    add_row(SYNC_BYTE_C, 1'b1, reply(1, KEY_REPLY, 0, 8'h00, 8'd0, 0, 8'h00, 1));
    // zero-length block ends on its length byte, still echoed
    add_row(8'h00, 1'b1, reply(1, 8'hFF, 1, 8'h00, 8'd0, 1, 8'h00, 1));
    // length one: counter byte is last, stored and not echoed
    add_row(8'h01, 1'b1, reply(1, 8'hFE, 1, 8'h01, 8'd0, 0, 8'h00, 1));
    add_row(8'hFF, 1'b1, reply(0, 8'h00, 1, 8'hFF, 8'd1, 1, 8'hFF, 1));
    // length two
    add_row(8'h02, 1'b1, reply(1, 8'hFD, 1, 8'h02, 8'd0, 0, 8'hFF, 1));
    add_row(8'h00, 1'b1, reply(1, 8'hFF, 1, 8'h00, 8'd1, 0, 8'h00, 1));
    add_row(8'h03, 1'b1, reply(0, 8'h00, 1, 8'h03, 8'd2, 1, 8'h00, 1));
    // sync byte values inside a block are plain data once linked
    add_row(8'h05, 1'b0, '0);
    add_row(8'h7F, 1'b0, '0);
    add_row(SYNC_BYTE_A, 1'b0, '0);
    add_row(SYNC_BYTE_B, 1'b0, '0);
    add_row(SYNC_BYTE_C, 1'b0, '0);
    add_row(8'h80, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rx_table[i])
      send_rx(rx_table[i].rx, rx_table[i].fixed, rx_table[i].want);

    // random blocks with random content; idling profile moves through three phases
    blocks = 0;
    while (items_sent < NUM_ITEMS) begin
      phase = items_sent * 3 / NUM_ITEMS;
      case (phase)
        0: begin
          src_idle_pct  = 10;
          sink_idle_pct = 54;
        end
        1: begin
          src_idle_pct  = 54;
          sink_idle_pct = 10;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      pick = $urandom_range(99);
      if (blocks == LONG_BLOCK_AT)
        len = 255;            // longest block, positions run up to 255
      else if (pick < 6)
        len = 0;
      else if (pick < 12)
        len = 1;
      else if (pick < 20)
        len = $urandom_range(40, 17);
      else
        len = $urandom_range(16, 2);
      send_rx(len[7:0], 1'b0, '0);
      for (int k = 0; k < len; k++)
        send_rx(8'($urandom_range(255)), 1'b0, '0);
      blocks++;
    end
    in_valid <= 1'b0;

    // drain the result channel, then give the pipeline time to show any stray result
    while (expected_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("tb_complement_echo_block_receiver: PASS");
    else
      $display("tb_complement_echo_block_receiver: FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/cebr_pkg.sv
hdl/cebr_in_stage.sv
hdl/cebr_decode.sv
hdl/cebr_out_stage.sv
hdl/complement_echo_block_receiver.sv
tb/tb_complement_echo_block_receiver.sv
